// File: rtl/pchk_pkg.sv
package pchk_pkg;

  localparam int unsigned MAX_VOCAB_DEF = 262144;

  localparam int unsigned ID_W     = 32;
  localparam int unsigned POS_W    = 19;
  localparam int unsigned EPOS_W   = 18;
  localparam int unsigned WORD_W   = 64;
  localparam int unsigned BIT_W    = 6;
  localparam int unsigned EPOCH_W  = 8;
  localparam int unsigned OUT_W    = 24;
  localparam int unsigned CFG_AW   = 3;
  localparam int unsigned CFG_DW   = 32;

  localparam int unsigned POS_MAX  = (2 ** POS_W) - 1;
  localparam int unsigned EPOS_MAX = (2 ** EPOS_W) - 1;

  localparam logic [POS_W-1:0] VOCAB_RESET = POS_W'(262144);

  // register index, taken from paddr[2]
  localparam logic REG_VOCAB = 1'b0;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_DUP   = 2'd2,
    ST_COUNT = 2'd3
  } status_t;

endpackage

// File: rtl/pchk_seen_map.sv
module pchk_seen_map
  import pchk_pkg::*;
#(
  parameter int unsigned WORDS = (MAX_VOCAB_DEF + WORD_W - 1) / WORD_W,
  parameter int unsigned AW    = 12
) (
  input  logic               clk,
  input  logic               rd_en,
  input  logic [AW-1:0]      rd_addr,
  input  logic [EPOCH_W-1:0] rd_epoch,
  input  logic               wr_en,
  input  logic [AW-1:0]      wr_addr,
  input  logic [WORD_W-1:0]  wr_word,
  input  logic [EPOCH_W-1:0] wr_epoch,
  output logic [WORD_W-1:0]  rd_word
);

  // entry: epoch tag above the seen word
  logic [EPOCH_W+WORD_W-1:0] mem [WORDS];

  logic [EPOCH_W+WORD_W-1:0] rd_r;
  logic [EPOCH_W-1:0]        tag_r;
  logic                      byp_r;
  logic [WORD_W-1:0]         byp_word_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_epoch, wr_word};
    end
    if (rd_en) begin
      rd_r       <= mem[rd_addr];
      tag_r      <= rd_epoch;
      byp_r      <= wr_en && (wr_addr == rd_addr) && (wr_epoch == rd_epoch);
      byp_word_r <= wr_word;
    end
  end

  // stale epoch reads as an empty word
  always_comb begin
    if (byp_r) begin
      rd_word = byp_word_r;
    end else if (rd_r[EPOCH_W+WORD_W-1:WORD_W] == tag_r) begin
      rd_word = rd_r[WORD_W-1:0];
    end else begin
      rd_word = '0;
    end
  end

endmodule

// File: rtl/permutation_checker.sv
// Permutation checker: takes a stream of target ids, one word per position,
// and checks that each run (closed by tlast) is a permutation of
// 0..vocab_size-1, vocab_size saturated to MAX_VOCAB.
// Input word: in_tdata is the signed 32-bit id, in_tlast closes the run.
// Result word, one per input word: item status, position of the first
// error of the run, run verdict; out_tlast marks the result of the last id.
// vocab_size is written over the APB port at byte address 0.
// An accepted id is registered into the check stage together with its seen
// word read, and its result is then registered in the result register.
// Throughput: one id per cycle unless the receiver stalls or a clearing
// pass runs; the seen bitmap is one read-modify-write per id on 64-bit words
// with an epoch tag, the write forwarded to a back-to-back read of that word.
// Runs are separated by an epoch tag on each memory word, so the bitmap
// needs no clearing between runs. After reset, and after every 256th run,
// a clearing pass over all ceil(MAX_VOCAB/64) words (4096 by default) runs
// with in_tready low, after the 256th run once the pipeline has drained.
// When the receiver stalls, the result register holds and one more id may
// be taken into the pipeline before in_tready drops.
module permutation_checker
  import pchk_pkg::*;
#(
  parameter int unsigned MAX_VOCAB = MAX_VOCAB_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [ID_W-1:0]   in_tdata,   // [31:0] id
  input  logic              in_tlast,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_W-1:0]  out_tdata,  // [1:0] item_status, [19:2] bad_position,
                                        // [20] run_valid, [23:21] zero
  output logic              out_tlast,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  localparam int unsigned WORDS = (MAX_VOCAB + WORD_W - 1) / WORD_W;
  localparam int unsigned AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int unsigned VCAP  = (MAX_VOCAB > POS_MAX) ? POS_MAX : MAX_VOCAB;
  localparam logic [POS_W-1:0] VCAP_V     = POS_W'(VCAP);
  localparam logic [AW-1:0]    CLR_LAST   = AW'(WORDS - 1);
  localparam logic [POS_W-1:0] POS_MAX_V  = POS_W'(POS_MAX);
  localparam logic [POS_W-1:0] EPOS_CAP_P = POS_W'(EPOS_MAX);
  localparam logic [EPOS_W-1:0] EPOS_CAP  = EPOS_W'(EPOS_MAX);

  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_RUN   = 3'b010,
    S_DRAIN = 3'b100
  } state_t;

  state_t              state_r, state_nxt;
  logic [AW-1:0]       clr_addr_r;
  logic [POS_W-1:0]    vocab_r;
  logic [POS_W-1:0]    pos_r;
  logic [EPOCH_W-1:0]  epoch_r;

  logic                s1_valid_r;
  status_t             s1_pre_r;
  logic [BIT_W-1:0]    s1_bit_r;
  logic [AW-1:0]       s1_addr_r;
  logic [EPOCH_W-1:0]  s1_epoch_r;
  logic                s1_short_r;
  logic                s1_last_r;
  logic [EPOS_W-1:0]   s1_epos_r;

  status_t             err_code_r;
  logic [EPOS_W-1:0]   err_pos_r;

  logic                out_valid_r;
  logic [OUT_W-1:0]    out_data_r;
  logic                out_last_r;

  logic                cfg_wr;
  logic [POS_W-1:0]    vocab_eff;
  logic                in_fire;
  logic                s1_adv;
  logic                cnt_err;
  logic                rng_err;
  logic                short_run;
  status_t             pre;
  logic [AW-1:0]       rd_addr;
  logic [WORD_W-1:0]   seen_word;
  logic                hit;
  status_t             status;
  logic                mark;
  status_t             err_now;
  logic [EPOS_W-1:0]   pos_now;
  logic                clearing;
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  logic [WORD_W-1:0]   wr_word;
  logic [EPOCH_W-1:0]  wr_epoch;
  logic                run_ok;
  logic [EPOS_W-1:0]   bad_pos;

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[2] == REG_VOCAB) begin
      cfg_prdata = CFG_DW'(vocab_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vocab_r <= VOCAB_RESET;
    end else if (cfg_wr && (cfg_paddr[2] == REG_VOCAB)) begin
      vocab_r <= cfg_pwdata[POS_W-1:0];
    end
  end

  // accept stage
  assign vocab_eff = (vocab_r > VCAP_V) ? VCAP_V : vocab_r;
  assign in_fire   = in_tvalid && in_tready;
  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = (state_r == S_RUN) && (!s1_valid_r || s1_adv);
  assign cnt_err   = pos_r >= vocab_eff;
  assign rng_err   = in_tdata[ID_W-1] || (in_tdata >= ID_W'(vocab_eff));
  assign short_run = in_tlast &&
                     (({1'b0, pos_r} + (POS_W+1)'(1)) < {1'b0, vocab_eff});
  assign rd_addr   = AW'(in_tdata[ID_W-1:BIT_W]);

  always_comb begin
    if (cnt_err) begin
      pre = ST_COUNT;
    end else if (rng_err) begin
      pre = ST_RANGE;
    end else begin
      pre = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_pre_r   <= pre;
      s1_bit_r   <= in_tdata[BIT_W-1:0];
      s1_addr_r  <= rd_addr;
      s1_epoch_r <= epoch_r;
      s1_short_r <= short_run;
      s1_last_r  <= in_tlast;
      s1_epos_r  <= (pos_r > EPOS_CAP_P) ? EPOS_CAP : pos_r[EPOS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      pos_r      <= '0;
      epoch_r    <= '0;
    end else begin
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (in_fire) begin
        if (in_tlast) begin
          pos_r   <= '0;
          epoch_r <= epoch_r + EPOCH_W'(1);
        end else if (pos_r < POS_MAX_V) begin
          pos_r <= pos_r + POS_W'(1);
        end
      end
    end
  end

  // bitmap
  assign clearing = (state_r == S_CLEAR);
  assign wr_en    = mark || clearing;
  assign wr_addr  = clearing ? clr_addr_r : s1_addr_r;
  assign wr_word  = clearing ? '0 : (seen_word | (WORD_W'(1) << s1_bit_r));
  assign wr_epoch = clearing ? '0 : s1_epoch_r;

  pchk_seen_map #(
    .WORDS (WORDS),
    .AW    (AW)
  ) u_seen_map (
    .clk      (clk),
    .rd_en    (in_fire),
    .rd_addr  (rd_addr),
    .rd_epoch (epoch_r),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_word  (wr_word),
    .wr_epoch (wr_epoch),
    .rd_word  (seen_word)
  );

  // check stage
  assign hit  = seen_word[s1_bit_r];
  assign mark = s1_adv && (s1_pre_r == ST_OK) && !hit;

  always_comb begin
    if (s1_pre_r != ST_OK) begin
      status = s1_pre_r;
    end else if (hit) begin
      status = ST_DUP;
    end else if (s1_short_r) begin
      status = ST_COUNT;
    end else begin
      status = ST_OK;
    end
  end

  assign err_now = (err_code_r != ST_OK) ? err_code_r : status;
  assign pos_now = (err_code_r != ST_OK) ? err_pos_r : s1_epos_r;
  assign run_ok  = s1_last_r && (err_now == ST_OK);
  assign bad_pos = (err_now != ST_OK) ? pos_now : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      err_code_r <= ST_OK;
    end else if (s1_adv) begin
      err_code_r <= s1_last_r ? ST_OK : err_now;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      err_pos_r <= pos_now;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data_r <= OUT_W'({run_ok, bad_pos, status});
      out_last_r <= s1_last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  // clearing sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (clr_addr_r == CLR_LAST) begin
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        if (in_fire && in_tlast && (epoch_r == '1)) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!s1_valid_r) begin
          state_nxt = S_CLEAR;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      clr_addr_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (clearing) begin
        clr_addr_r <= (clr_addr_r == CLR_LAST) ? '0 : clr_addr_r + AW'(1);
      end
    end
  end

  // checks
  a_clear_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !s1_valid_r)
    else $error("clearing pass overlaps a bitmap update");

  a_valid_run_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r[EPOS_W+2]) |->
      (out_last_r && (out_data_r[1:0] == ST_OK)))
    else $error("run verdict valid with a failing last word");

  a_err_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_last_r) |=> (err_code_r == ST_OK))
    else $error("latched error survives the end of a run");

  a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DRAIN) |=> !(s1_valid_r && $past(in_fire)))
    else $error("word accepted while draining for a clearing pass");

endmodule

// File: tb/tb_top.sv
module tb_top;
  import pchk_pkg::*;

  localparam int unsigned MAXV = MAX_VOCAB_DEF;
  localparam int unsigned IDLE_LIMIT = 20000;
  localparam int unsigned LONG_HOLD = 400;
  localparam int unsigned RANDOM_WORDS = 1500;
  localparam logic [CFG_AW-1:0] VOCAB_ADDR = CFG_AW'({REG_VOCAB, 2'b00});

  typedef struct packed {
    status_t            status;
    logic [EPOS_W-1:0]  bad_pos;
    logic               perm_ok;
    logic               run_end;
  } result_t;

  typedef struct packed {
    logic              has_cfg;
    logic [CFG_DW-1:0] cfg_val;
    logic [ID_W-1:0]   id;
    logic              is_last;
    logic              typed;
    status_t           status;
    logic [EPOS_W-1:0] bad_pos;
    logic              perm_ok;
  } row_t;

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [ID_W-1:0]   in_tdata;   // [31:0] id
  logic              in_tlast;
  logic              out_tvalid;
  logic              out_tready;
  logic [OUT_W-1:0]  out_tdata;  // [1:0] item_status, [19:2] bad_position,
                                 // [20] run_valid, [23:21] zero
  logic              out_tlast;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  // shadow of the checker state
  logic [POS_W-1:0]  vocab_reg = VOCAB_RESET;
  logic [POS_W-1:0]  pos = '0;
  status_t           err_code = ST_OK;
  logic [EPOS_W-1:0] err_pos = '0;
  bit                id_seen [MAXV];
  int unsigned       marked_ids[$];

  result_t     due_results[$];
  row_t        rows[$];
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned idle_cycles = 0;
  bit          hold_req = 1'b0;
  bit          src_gappy = 1'b0;
  bit          sink_gappy = 1'b0;

  permutation_checker #(
    .MAX_VOCAB(MAXV)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(40, 120);
  endfunction

  // status of one id, with the run state moved on
  function automatic result_t judge_id(input logic [ID_W-1:0] id, input logic is_last);
    result_t     r;
    int unsigned v;
    status_t     st;
    v = (vocab_reg > MAXV) ? MAXV : vocab_reg;
    st = ST_OK;
    if (pos >= v) begin
      st = ST_COUNT;
    end else if (id[ID_W-1] || id >= v) begin
      st = ST_RANGE;
    end else if (id_seen[id]) begin
      st = ST_DUP;
    end else begin
      id_seen[id] = 1'b1;
      marked_ids.push_back(id);
    end
    if (st == ST_OK && is_last && pos + 1 < v) st = ST_COUNT;
    if (err_code == ST_OK && st != ST_OK) begin
      err_code = st;
      err_pos = (pos > EPOS_MAX) ? EPOS_W'(EPOS_MAX) : pos[EPOS_W-1:0];
    end
    r.status = st;
    r.bad_pos = (err_code != ST_OK) ? err_pos : '0;
    r.perm_ok = is_last && err_code == ST_OK;
    r.run_end = is_last;
    if (is_last) begin
      foreach (marked_ids[i]) id_seen[marked_ids[i]] = 1'b0;
      marked_ids.delete();
      pos = '0;
      err_code = ST_OK;
      err_pos = '0;
    end else if (pos < POS_MAX) begin
      pos++;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    $display("mismatch in %s at result %0d: got 0x%0h, want 0x%0h (t=%0t)",
             what, results_seen, got, want, $time);
  endtask

  task automatic send_word(input logic [ID_W-1:0] id, input logic is_last,
                           input bit typed, input result_t typed_res);
    result_t r;
    int      gap;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= id;
    in_tlast  <= is_last;
    do @(posedge clk); while (in_tready !== 1'b1);
    r = judge_id(id, is_last);
    due_results.push_back(typed ? typed_res : r);
    gap = (src_gappy && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      in_tdata  <= $urandom;
      in_tlast  <= $urandom_range(0, 1);
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // stop offering words and wait for every result to come back
  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
  endtask

  // write then read back vocab_size in two back-to-back transfers
  task automatic write_vocab(input logic [CFG_DW-1:0] value);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= VOCAB_ADDR;
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    vocab_reg = value[POS_W-1:0];
    @(negedge clk);
    cfg_pwrite  <= 1'b0;
    cfg_penable <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    if (cfg_prdata !== CFG_DW'(vocab_reg))
      report_mismatch("vocab_size readback", cfg_prdata, CFG_DW'(vocab_reg));
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic add_row(input logic has_cfg, input logic [CFG_DW-1:0] cfg_val,
                         input logic [ID_W-1:0] id, input logic is_last,
                         input logic typed, input status_t status,
                         input logic [EPOS_W-1:0] bad_pos, input logic perm_ok);
    row_t r;
    r.has_cfg = has_cfg;
    r.cfg_val = cfg_val;
    r.id      = id;
    r.is_last = is_last;
    r.typed   = typed;
    r.status  = status;
    r.bad_pos = bad_pos;
    r.perm_ok = perm_ok;
    rows.push_back(r);
  endtask

  task automatic check_result();
    result_t want;
    if (due_results.size() == 0) begin
      report_mismatch("unexpected result word", 32'(out_tdata), '0);
    end else begin
      want = due_results.pop_front();
      if (out_tdata[1:0] !== want.status)
        report_mismatch("item_status", 32'(out_tdata[1:0]), 32'(want.status));
      if (out_tdata[EPOS_W+1:2] !== want.bad_pos)
        report_mismatch("bad_position", 32'(out_tdata[EPOS_W+1:2]),
                        32'(want.bad_pos));
      if (out_tdata[EPOS_W+2] !== want.perm_ok)
        report_mismatch("run_valid", 32'(out_tdata[EPOS_W+2]), 32'(want.perm_ok));
      if (out_tdata[OUT_W-1:EPOS_W+3] !== '0)
        report_mismatch("padding", 32'(out_tdata[OUT_W-1:EPOS_W+3]), '0);
      if (out_tlast !== want.run_end)
        report_mismatch("run_end", 32'(out_tlast), 32'(want.run_end));
    end
    results_seen++;
  endtask

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (idle_cycles >= IDLE_LIMIT);
    $display("tb_top: FAIL");
    $finish;
  end

  initial begin : result_sink
    logic rdy;
    int   stall_left;
    int   hold_left;
    stall_left = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (out_tvalid === 1'b1 && out_tready === 1'b1) check_result();
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rdy = 1'b0;
      end else begin
        rdy = 1'b1;
        if (sink_gappy && $urandom_range(0, 2) == 0) stall_left = pick_gap();
      end
      @(negedge clk);
      out_tready <= rdy;
    end
  end

  initial begin
    result_t         typed_res;
    result_t         no_res;
    row_t            row;
    logic [ID_W-1:0] ids[$];
    logic [ID_W-1:0] tmp;
    logic [CFG_DW-1:0] cfgv;
    int unsigned     v;
    int unsigned     ve;
    int unsigned     sent;
    int              n_runs;
    int              kind;
    int              k;
    int              j;
    int              c;
    int              phase;
    bit              closed;

    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tlast    <= 1'b0;
    out_tready  <= 1'b0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    no_res = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // vocab at reset value
    add_row(0, 0, 32'h0000_0000, 0, 1, ST_OK,    0, 0);
    add_row(0, 0, 32'hFFFF_FFFF, 0, 1, ST_RANGE, 1, 0);
    add_row(0, 0, 32'h7FFF_FFFF, 1, 1, ST_RANGE, 1, 0);
    // single entry permutation, then wrong id and overlong run
    add_row(1, 1, 32'd0, 1, 1, ST_OK,    0, 1);
    add_row(0, 0, 32'd1, 0, 1, ST_RANGE, 0, 0);
    add_row(0, 0, 32'd0, 0, 1, ST_COUNT, 0, 0);
    add_row(0, 0, 32'd0, 1, 1, ST_COUNT, 0, 0);
    // duplicate, most negative id, errors keep being checked after the first
    add_row(1, 4, 32'd2, 0, 1, ST_OK,    0, 0);
    add_row(0, 0, 32'd2, 0, 1, ST_DUP,   1, 0);
    add_row(0, 0, 32'h8000_0000, 0, 1, ST_RANGE, 1, 0);
    add_row(0, 0, 32'd3, 1, 1, ST_OK,    1, 0);
    // last too early
    add_row(0, 0, 32'd1, 1, 1, ST_COUNT, 0, 0);
    add_row(0, 0, 32'd3, 0, 0, ST_OK,    0, 0);
    add_row(0, 0, 32'd0, 0, 0, ST_OK,    0, 0);
    add_row(0, 0, 32'd2, 0, 0, ST_OK,    0, 0);
    add_row(0, 0, 32'd1, 1, 1, ST_OK,    0, 1);
    // zero size never passes
    add_row(1, 0, 32'd0, 1, 1, ST_COUNT, 0, 0);
    // oversized register saturates
    add_row(1, 32'h0007_FFFF, 32'd262143, 0, 1, ST_OK,    0, 0);
    add_row(0, 0,             32'd262144, 0, 1, ST_RANGE, 1, 0);
    // size change in the middle of a run
    add_row(1, 2, 32'd0, 1, 1, ST_COUNT, 1, 0);
    // upper write bits ignored
    add_row(1, 32'hFFF8_0002, 32'd1, 0, 1, ST_OK, 0, 0);
    add_row(0, 0,             32'd0, 1, 1, ST_OK, 0, 1);

    foreach (rows[i]) begin
      row = rows[i];
      if (row.has_cfg) begin
        drain();
        write_vocab(row.cfg_val);
      end
      typed_res.status  = row.status;
      typed_res.bad_pos = row.bad_pos;
      typed_res.perm_ok = row.perm_ok;
      typed_res.run_end = row.is_last;
      send_word(row.id, row.is_last, row.typed, typed_res);
    end

    sent = 0;
    phase = 0;
    while (sent < RANDOM_WORDS) begin
      drain();
      c = $urandom_range(0, 99);
      if (c < 60)      v = $urandom_range(1, 16);
      else if (c < 80) v = $urandom_range(17, 130);
      else if (c < 88) v = $urandom_range(131, 300);
      else if (c < 92) v = 0;
      else if (c < 96) v = MAXV;
      else             v = $urandom_range(MAXV + 1, POS_MAX);
      cfgv = v;
      if ($urandom_range(0, 3) == 0) cfgv = cfgv | ($urandom & ~CFG_DW'(POS_MAX));
      write_vocab(cfgv);
      ve = (v > MAXV) ? MAXV : v;
      src_gappy = $urandom_range(0, 2) != 0;
      sink_gappy = $urandom_range(0, 2) != 0;
      n_runs = $urandom_range(1, 6);
      if (phase == 2 || $urandom_range(0, 19) == 0) begin
        hold_req = 1'b1;
        src_gappy = 1'b0;
        n_runs = 6;
      end
      repeat (n_runs) begin
        kind = $urandom_range(0, 99);
        ids.delete();
        closed = 1'b1;
        if (kind < 80 && ve >= 1 && ve <= 300) begin
          for (int i = 0; i < ve; i++) ids.push_back(i);
          for (int i = ids.size() - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            tmp = ids[i];
            ids[i] = ids[j];
            ids[j] = tmp;
          end
        end else if (kind < 80) begin
          repeat ($urandom_range(1, 20))
            ids.push_back(ve == 0 ? $urandom : $urandom_range(0, ve - 1));
        end
        // broken tables
        if (kind >= 55 && kind < 80) begin
          k = $urandom_range(0, ids.size() - 1);
          case ($urandom_range(0, 5))
            0: if (ids.size() > 1) begin
              k = $urandom_range(1, ids.size() - 1);
              ids[k] = ids[$urandom_range(0, k - 1)];
            end
            1: ids[k] = ve + $urandom_range(0, 3);
            2: ids[k] = $urandom | 32'h8000_0000;
            3: ids[k] = $urandom;
            4: repeat ($urandom_range(1, ids.size()))
              if (ids.size() > 1) tmp = ids.pop_back();
            default: repeat ($urandom_range(1, 4)) ids.push_back($urandom_range(0, ve + 1));
          endcase
        end
        if (kind >= 80) begin
          repeat ($urandom_range(1, 24)) begin
            c = $urandom_range(0, 2);
            if (c == 0)      ids.push_back($urandom);
            else if (c == 1) ids.push_back(ve == 0 ? 0 : $urandom_range(0, ve - 1));
            else             ids.push_back($urandom_range(0, ve + 2));
          end
          closed = $urandom_range(0, 2) != 0;
        end
        for (int i = 0; i < ids.size(); i++) begin
          send_word(ids[i], closed && (i == ids.size() - 1), 1'b0, no_res);
          sent++;
        end
      end
      phase++;
    end

    drain();
    repeat (16) @(posedge clk);
    if (due_results.size() != 0)
      report_mismatch("results never delivered", 32'(due_results.size()), '0);
    if (mismatches == 0)
      $display("tb_top: PASS");
    else
      $display("tb_top: FAIL");
    $finish;
  end

endmodule

// File: permutation_checker.f
rtl/pchk_pkg.sv
rtl/pchk_seen_map.sv
rtl/permutation_checker.sv
tb/tb_top.sv
